FILE: src/ptd_pkg.sv
// Package for the periodic task dispatcher: request and result transfer types,
// request codes, the slot record kept in memory and the slot update result.
// No dependencies.
package ptd_pkg;

   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_RUN     = 3'd1;
   localparam logic [2:0] REQ_CREATE  = 3'd2;
   localparam logic [2:0] REQ_DISABLE = 3'd3;
   localparam logic [2:0] REQ_RESUME  = 3'd4;
   localparam logic [2:0] REQ_SETPER  = 3'd5;
   localparam logic [2:0] REQ_QUERY   = 3'd6;

   localparam logic KIND_FIRE  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [14:0]        IDLE_PERIOD   = 15'd30000;
   localparam logic signed [15:0] CD_DISPATCHED = -16'sd1;
   localparam logic [3:0]         MAX_FIRES     = 4'd8;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [2:0]         slot;
      logic signed [15:0] repeat_count;
      logic [14:0]        period_value;
   } req_item_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] fired_slot;
      logic       busy_res;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic signed [15:0] repeats;
      logic [14:0]        period;
      logic signed [15:0] countdown;
   } slot_word_type;

   localparam int SLOT_WORD_W = $bits(slot_word_type);

   typedef enum logic [1:0] {
      OP_TICK,
      OP_RUN,
      OP_SETPER
   } slot_op_type;

   typedef struct packed {
      slot_word_type word;
      logic          active;
      logic          fire;
   } slot_upd_type;

endpackage

FILE: src/ptd_ram.sv
// Generic single-clock RAM: one write port and one read port with registered
// read data. No dependencies.
module ptd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ptd_slot_alu.sv
// Shared slot update unit: computes the new record, active flag and fire flag
// of one slot for a tick, a run scan step or a set period.
// Depends on ptd_pkg.
module ptd_slot_alu
   import ptd_pkg::*;
(
   input  slot_op_type   op,
   input  slot_word_type word_cur,
   input  logic          active_cur,
   input  logic [14:0]   period_new,
   output slot_upd_type  upd
);

   always_comb begin
      upd.word   = word_cur;
      upd.active = active_cur;
      upd.fire   = 1'b0;
      case (op)
         OP_TICK: begin
            if (word_cur.countdown > 16'sd0) begin
               upd.word.countdown = word_cur.countdown - 16'sd1;
            end
         end
         OP_RUN: begin
            if (active_cur && word_cur.countdown == 16'sd0) begin
               upd.word.countdown = CD_DISPATCHED;
               if (word_cur.repeats != 16'sd0) begin
                  upd.word.countdown = signed'({1'b0, word_cur.period});
                  upd.fire           = 1'b1;
               end
               if (word_cur.repeats > 16'sd0) begin
                  upd.word.repeats = word_cur.repeats - 16'sd1;
                  if (word_cur.repeats == 16'sd1) begin
                     upd.active = 1'b0;
                  end
               end
            end
         end
         OP_SETPER: begin
            upd.word.period = (period_new == 15'd0) ? IDLE_PERIOD : period_new;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: src/periodic_task_dispatcher_unit.sv
// Top level of the periodic task dispatcher: command sequencer, slot memory,
// active and written flags, and the registered result port.
// Depends on ptd_pkg, ptd_ram and ptd_slot_alu.
//
// A command is taken when start is high and busy is low. Create, disable,
// resume, query and unknown commands leave busy low. Set period of a slot in
// range is a read-modify-write of that slot and keeps busy high until the
// slot is written back. A tick walks every slot in the LOOP state; a run
// scan walks every slot and then closes out in the FLUSH state. The walk
// handles one slot per cycle, which is what the slot memory allows with its
// one read and one write port feeding the single shared slot update unit.
// Results leave through a register and are shown for exactly one cycle with
// rsp_strobe; the receiver cannot hold them off, so it must take every strobe.
// A query answer appears in the cycle after its transfer. Each fire result of
// a run scan is held back until the next fire or the end of the scan shows
// whether it is the final result of the command; at most eight fire results
// are produced per scan, although every due slot is still updated. The slot
// memory needs no clearing pass: a flag per slot marks entries that have been
// written, and an unwritten entry reads as zero.
module periodic_task_dispatcher_unit
   import ptd_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int              IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [6:0]       SLOTS_L  = 7'(NUM_SLOTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOP,
      S_FLUSH
   } state_type;

   state_type         state_ff, state_in;
   slot_op_type       op_ff, op_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              single_ff, single_in;
   logic [14:0]       per_ff, per_in;
   logic [3:0]        fire_cnt_ff, fire_cnt_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [2:0]        pend_slot_ff, pend_slot_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic              rd_valid_ff, rd_valid_in;

   logic              accept;
   logic [6:0]        slot_ext;
   logic [6:0]        idx_ext;
   logic              slot_ok;
   logic [IDX_W-1:0]  cmd_addr;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   slot_word_type     wr_word;
   logic [SLOT_WORD_W-1:0] rd_data;
   slot_word_type     cur_word;
   slot_upd_type      upd;
   logic              scan_end;

   assign accept   = start && (state_ff == S_IDLE);
   assign slot_ext = 7'(req_item.slot);
   assign idx_ext  = 7'(idx_ff);
   assign slot_ok  = slot_ext < SLOTS_L;
   assign cmd_addr = slot_ext[IDX_W-1:0];
   assign scan_end = single_ff || (idx_ff == LAST_IDX);

   // The walk reads the next slot while the current one is written back.
   always_comb begin
      if (state_ff == S_LOOP) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else if (req_item.req_type == REQ_SETPER) begin
         rd_addr = cmd_addr;
      end else begin
         rd_addr = '0;
      end
   end

   ptd_ram #(
      .WIDTH(SLOT_WORD_W),
      .DEPTH(NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entries never written read as the reset record of all zeros.
   assign cur_word = rd_valid_ff ? slot_word_type'(rd_data) : '0;

   ptd_slot_alu u_alu (
      .op         (op_ff),
      .word_cur   (cur_word),
      .active_cur (active_ff[idx_ff]),
      .period_new (per_ff),
      .upd        (upd)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      single_in     = single_ff;
      per_in        = per_ff;
      fire_cnt_in   = fire_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      active_in     = active_ff;
      valid_in      = valid_ff;
      rd_valid_in   = valid_ff[rd_addr];
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_word       = upd.word;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_item.req_type)
                  REQ_TICK, REQ_RUN: begin
                     op_in         = (req_item.req_type == REQ_TICK) ? OP_TICK : OP_RUN;
                     idx_in        = '0;
                     single_in     = 1'b0;
                     fire_cnt_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_LOOP;
                  end
                  REQ_SETPER: begin
                     if (slot_ok) begin
                        op_in     = OP_SETPER;
                        idx_in    = cmd_addr;
                        single_in = 1'b1;
                        per_in    = req_item.period_value;
                        state_in  = S_LOOP;
                     end
                  end
                  REQ_CREATE: begin
                     if (slot_ok) begin
                        wr_en                = 1'b1;
                        wr_addr              = cmd_addr;
                        wr_word.repeats      = req_item.repeat_count;
                        wr_word.period       = req_item.period_value;
                        wr_word.countdown    = signed'({1'b0, req_item.period_value});
                        active_in[cmd_addr]  = 1'b1;
                        valid_in[cmd_addr]   = 1'b1;
                     end
                  end
                  REQ_DISABLE, REQ_RESUME: begin
                     if (slot_ok) begin
                        active_in[cmd_addr] = (req_item.req_type == REQ_RESUME);
                     end
                  end
                  REQ_QUERY: begin
                     rsp_strobe_in          = 1'b1;
                     rsp_item_in.kind       = KIND_QUERY;
                     rsp_item_in.fired_slot = req_item.slot;
                     rsp_item_in.busy_res   = slot_ok && active_ff[cmd_addr];
                     rsp_item_in.last       = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOOP: begin
            wr_en            = 1'b1;
            active_in[idx_ff] = upd.active;
            valid_in[idx_ff]  = 1'b1;
            // A fire is held back until the next fire or the end of the scan
            // tells whether it is the final result of the command.
            if (upd.fire && fire_cnt_ff < MAX_FIRES) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in          = 1'b1;
                  rsp_item_in.kind       = KIND_FIRE;
                  rsp_item_in.fired_slot = pend_slot_ff;
                  rsp_item_in.busy_res   = 1'b0;
                  rsp_item_in.last       = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = idx_ext[2:0];
               fire_cnt_in   = fire_cnt_ff + 4'd1;
            end
            if (scan_end) begin
               state_in = (op_ff == OP_RUN) ? S_FLUSH : S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in          = 1'b1;
               rsp_item_in.kind       = KIND_FIRE;
               rsp_item_in.fired_slot = pend_slot_ff;
               rsp_item_in.busy_res   = 1'b0;
               rsp_item_in.last       = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_TICK;
         idx_ff        <= '0;
         single_ff     <= 1'b0;
         fire_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         active_ff     <= '0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         idx_ff        <= idx_in;
         single_ff     <= single_in;
         fire_cnt_ff   <= fire_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         active_ff     <= active_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
      end
      per_ff       <= per_in;
      pend_slot_ff <= pend_slot_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

FILE: src/ptd_checker.sv
// Port-level checker for the periodic task dispatcher, bound to the top level.
// Depends on ptd_pkg and periodic_task_dispatcher_unit.
module ptd_checker
   import ptd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_strobe,
   input rsp_item_type rsp_item
);

   // A query answers in the next cycle, naming the queried slot, as the final result.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.req_type == REQ_QUERY |=>
         rsp_strobe && rsp_item.kind == KIND_QUERY && rsp_item.last &&
         rsp_item.fired_slot == $past(req_item.slot))
      else $error("query transfer not answered in the next cycle");

   // Any other command shows no result in the cycle after its transfer.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.req_type != REQ_QUERY |=> !rsp_strobe)
      else $error("unexpected result right after a non-query transfer");

   // Fire results come only out of a scan in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == KIND_FIRE |-> $past(busy))
      else $error("fire result outside a scan");

   // A fire result never reports the slot as busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == KIND_FIRE |-> !rsp_item.busy_res)
      else $error("fire result with busy_res set");

endmodule

bind periodic_task_dispatcher_unit ptd_checker u_ptd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
